>>> src/feature_running_statistics_top_assert.svh
// Assertion macros shared by the feature statistics RTL.
`ifndef FEATURE_RUNNING_STATISTICS_TOP_ASSERT_SVH
`define FEATURE_RUNNING_STATISTICS_TOP_ASSERT_SVH

// Checks that an implication holds on every clock edge outside reset.
`define FRS_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Checks that an implication holds in the cycle after its condition, outside reset.
`define FRS_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> src/frs_pkg.sv
package frs_pkg;

    // Sequencer states of the statistics block.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_DIV,
        ST_MEAN,
        ST_MUL,
        ST_MULACC,
        ST_WRITE,
        ST_OUT
    } t_state;

    localparam int SAMPLE_W = 32;
    localparam int COUNT_W  = 32;
    localparam int M2_W     = 48;
    localparam int INDEX_W  = 10;
    localparam int DELTA_W  = 33;

    localparam logic [SAMPLE_W-1:0] MIN_RESET = 32'h7FFF_FFFF;
    localparam logic [SAMPLE_W-1:0] MAX_RESET = 32'h8000_0000;
    localparam logic [M2_W-1:0]     M2_MAX    = 48'hFFFF_FFFF_FFFF;

endpackage

>>> src/feature_running_statistics_top.sv
// Per-index running statistics (Welford online mean and variance).
// An item is taken with start while busy is low: a 10-bit index and a
// signed Q16.16 sample. The block answers each item with one result, shown
// for one cycle under o_done: out-of-range and zero-skip flags, and the
// entry's count, mean, M2, minimum, maximum and the highest index updated.
// The receiver cannot stall; results simply appear when ready.
// A nonzero in-range sample passes through read, load, a 33-step restoring
// divider for delta/count, the new mean, a 33-step shift-add multiplier for
// the M2 term, accumulate, write and output. Zero samples and out-of-range
// indexes go from read and load straight to output and are not written
// back. One item is worked on at a time; the next item can be taken in the
// cycle after the result. The table lives in one synchronous memory with a
// registered read; an updated entry is written back at the end of its item.
// After reset a clearing pass writes every entry once while busy is high.
module feature_running_statistics_top
    import frs_pkg::*;
#(
    parameter int TABLE_ENTRIES = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [INDEX_W-1:0]         i_feature_index,
    input  logic signed [SAMPLE_W-1:0] i_feature_sample,
    output logic                       o_done,
    output logic                       o_index_out_of_range,
    output logic                       o_zero_skipped,
    output logic [COUNT_W-1:0]         o_entry_count,
    output logic signed [SAMPLE_W-1:0] o_entry_mean,
    output logic [M2_W-1:0]            o_entry_m2,
    output logic signed [SAMPLE_W-1:0] o_entry_minimum,
    output logic signed [SAMPLE_W-1:0] o_entry_maximum,
    output logic [INDEX_W-1:0]         o_highest_index_seen
);

`include "feature_running_statistics_top_assert.svh"

    localparam int ADDR_W  = $clog2(TABLE_ENTRIES);
    localparam int ENTRY_W = COUNT_W + SAMPLE_W + M2_W + 2 * SAMPLE_W;
    localparam int CLR_W   = ADDR_W + 1;
    localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(TABLE_ENTRIES - 1);

    typedef struct packed {
        logic [COUNT_W-1:0]         count;
        logic signed [SAMPLE_W-1:0] mean;
        logic [M2_W-1:0]            m2;
        logic signed [SAMPLE_W-1:0] minimum;
        logic signed [SAMPLE_W-1:0] maximum;
    } t_entry;

    // Entry memory, one port for read and one for write.
    t_entry             mem [TABLE_ENTRIES];
    t_entry             r_rd_data;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    t_entry             mem_wdata;

    t_state r_state, n_state;
    logic [CLR_W-1:0]           r_clr, n_clr;
    logic [ADDR_W-1:0]          r_addr, n_addr;
    logic signed [SAMPLE_W-1:0] r_x, n_x;
    logic                       r_oor, n_oor;
    logic                       r_zero, n_zero;
    t_entry                     r_ent, n_ent;
    logic [INDEX_W-1:0]         r_high, n_high;
    logic                       r_neg, n_neg;
    logic [DELTA_W-1:0]         r_dm, n_dm;
    logic [DELTA_W-1:0]         r_quo, n_quo;
    logic [COUNT_W:0]           r_rem, n_rem;
    logic [5:0]                 r_step, n_step;
    logic [DELTA_W-1:0]         r_d2, n_d2;
    logic [2*DELTA_W-1:0]       r_prod, n_prod;

    logic                       idx_ok;
    logic [COUNT_W:0]           rem_sh;
    logic signed [SAMPLE_W:0]   mean_ext, mnew_ext, d2_s;
    logic [M2_W:0]              m2_sum;
    logic [2*DELTA_W-1:0]       prod_sh;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[r_addr];
    end

    assign idx_ok = ({1'b0, i_feature_index} < (INDEX_W+1)'(TABLE_ENTRIES))
                    || (TABLE_ENTRIES >= 1024);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (r_clr == CLR_LAST) n_state = ST_IDLE;
            ST_IDLE:   if (start) n_state = ST_READ;
            ST_READ:   n_state = ST_LOAD;
            ST_LOAD:   n_state = (r_oor || r_zero) ? ST_OUT : ST_DIV;
            ST_DIV:    if (r_step == 6'd0) n_state = ST_MEAN;
            ST_MEAN:   n_state = ST_MUL;
            ST_MUL:    if (r_step == 6'd0) n_state = ST_MULACC;
            ST_MULACC: n_state = ST_WRITE;
            ST_WRITE:  n_state = ST_OUT;
            ST_OUT:    n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Datapath updates.
    always_comb begin
        n_clr  = r_clr;
        n_addr = r_addr;
        n_x    = r_x;
        n_oor  = r_oor;
        n_zero = r_zero;
        n_ent  = r_ent;
        n_high = r_high;
        n_neg  = r_neg;
        n_dm   = r_dm;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_step = r_step;
        n_d2   = r_d2;
        n_prod = r_prod;
        rem_sh = '0;
        mean_ext = '0;
        mnew_ext = '0;
        d2_s     = '0;
        m2_sum   = '0;
        prod_sh  = '0;
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = r_ent;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr[ADDR_W-1:0];
                mem_wdata = '{count: '0, mean: '0, m2: '0,
                              minimum: MIN_RESET, maximum: MAX_RESET};
                n_clr = r_clr + 1'b1;
            end
            ST_IDLE: begin
                if (start) begin
                    n_addr = ADDR_W'(i_feature_index);
                    n_x    = i_feature_sample;
                    n_oor  = !idx_ok;
                    n_zero = idx_ok && (i_feature_sample == '0);
                end
            end
            ST_READ: begin
            end
            ST_LOAD: begin
                // Bump the count and form |delta| for the divider.
                n_ent = r_rd_data;
                if (r_oor) begin
                    n_ent = '0;
                end else if (!r_zero) begin
                    if (r_rd_data.count != '1) begin
                        n_ent.count = r_rd_data.count + 1'b1;
                    end
                    mean_ext = {r_rd_data.mean[SAMPLE_W-1], r_rd_data.mean};
                    d2_s  = {r_x[SAMPLE_W-1], r_x} - mean_ext;
                    n_neg = d2_s[SAMPLE_W];
                    n_dm  = d2_s[SAMPLE_W] ? DELTA_W'(-d2_s) : DELTA_W'(d2_s);
                    n_quo = '0;
                    n_rem = '0;
                    n_step = 6'(DELTA_W - 1);
                    if (r_x < r_rd_data.minimum) n_ent.minimum = r_x;
                    if (r_x > r_rd_data.maximum) n_ent.maximum = r_x;
                    if (INDEX_W'(r_addr) > r_high) n_high = INDEX_W'(r_addr);
                end
            end
            ST_DIV: begin
                // One quotient bit per cycle, restoring division.
                rem_sh = {r_rem[COUNT_W-1:0], r_dm[DELTA_W-1]};
                n_dm   = {r_dm[DELTA_W-2:0], 1'b0};
                if (rem_sh >= {1'b0, r_ent.count}) begin
                    n_rem = rem_sh - {1'b0, r_ent.count};
                    n_quo = {r_quo[DELTA_W-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh;
                    n_quo = {r_quo[DELTA_W-2:0], 1'b0};
                end
                n_step = r_step - 1'b1;
            end
            ST_MEAN: begin
                // New mean, then both magnitudes for the product.
                mean_ext = {r_ent.mean[SAMPLE_W-1], r_ent.mean};
                mnew_ext = r_neg ? mean_ext - $signed(r_quo)
                                 : mean_ext + $signed(r_quo);
                n_ent.mean = SAMPLE_W'(mnew_ext);
                d2_s = {r_x[SAMPLE_W-1], r_x} - mnew_ext;
                mean_ext = {r_x[SAMPLE_W-1], r_x} - mean_ext;
                n_dm = mean_ext[SAMPLE_W] ? DELTA_W'(-mean_ext) : DELTA_W'(mean_ext);
                if ((r_neg && !d2_s[SAMPLE_W] && d2_s != '0)
                        || (!r_neg && d2_s[SAMPLE_W])) begin
                    n_d2 = '0;
                end else begin
                    n_d2 = d2_s[SAMPLE_W] ? DELTA_W'(-d2_s) : DELTA_W'(d2_s);
                end
                n_prod = '0;
                n_step = 6'(DELTA_W - 1);
            end
            ST_MUL: begin
                // Shift-add multiply, one multiplier bit per cycle, MSB first.
                prod_sh = {r_prod[2*DELTA_W-2:0], 1'b0};
                if (r_d2[r_step[5:0]]) begin
                    n_prod = prod_sh + {{DELTA_W{1'b0}}, r_dm};
                end else begin
                    n_prod = prod_sh;
                end
                n_step = r_step - 1'b1;
            end
            ST_MULACC: begin
                // Q32.32 to Q32.16 and a saturating add to M2.
                prod_sh = r_prod >> 16;
                if (prod_sh[2*DELTA_W-1:M2_W] != '0) begin
                    n_ent.m2 = M2_MAX;
                end else begin
                    m2_sum = {1'b0, r_ent.m2} + {1'b0, prod_sh[M2_W-1:0]};
                    n_ent.m2 = m2_sum[M2_W] ? M2_MAX : m2_sum[M2_W-1:0];
                end
            end
            ST_WRITE: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr;
                mem_wdata = r_ent;
            end
            ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_high  <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_high  <= n_high;
        end
        r_addr <= n_addr;
        r_x    <= n_x;
        r_oor  <= n_oor;
        r_zero <= n_zero;
        r_ent  <= n_ent;
        r_neg  <= n_neg;
        r_dm   <= n_dm;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_step <= n_step;
        r_d2   <= n_d2;
        r_prod <= n_prod;
    end

    // Outputs.
    always_comb begin
        busy   = (r_state != ST_IDLE);
        o_done = (r_state == ST_OUT);
        o_index_out_of_range = r_oor;
        o_zero_skipped       = r_zero;
        o_entry_count        = r_ent.count;
        o_entry_mean         = r_ent.mean;
        o_entry_m2           = r_ent.m2;
        o_entry_minimum      = r_ent.minimum;
        o_entry_maximum      = r_ent.maximum;
        o_highest_index_seen = r_high;
    end

    `FRS_ASSERT_NEXT(a_start_reads, i_clk, i_rst_n, (r_state == ST_IDLE) && start,
        r_state == ST_READ, "accepted item did not start a read")
    `FRS_ASSERT_IMPL(a_flags_excl, i_clk, i_rst_n, o_done,
        !(o_index_out_of_range && o_zero_skipped), "both skip flags set")
    `FRS_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done,
        !o_done, "result shown for more than one cycle")
    `FRS_ASSERT_IMPL(a_no_write_idle, i_clk, i_rst_n, r_state == ST_IDLE,
        !mem_we, "memory written while idle")

endmodule
